FILE: rtl/core/swmm_pkg.sv
// Shared types and constants for the sliding window min/max block.
// Used by every module in rtl/core; depends on nothing.
package swmm_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_WIDTH    = 7;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           start_of_sequence;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] window_min;
        logic signed [SAMPLE_WIDTH-1:0] window_max;
    } out_item_t;

    // running extremes held by one cell
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
    } minmax_t;

endpackage

FILE: rtl/core/swmm_cell.sv
// One cell of the window chain: min and max over the last (position+1) samples.
// Depends on swmm_pkg.
module swmm_cell
    import swmm_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  minmax_t                        prev,
    output minmax_t                        cur
);

    minmax_t cur_reg;
    minmax_t cur_next;

    // extremes over one more sample = neighbor's old extremes folded with the new sample
    always_comb
    begin
        cur_next.lo = (sample < prev.lo) ? sample : prev.lo;
        cur_next.hi = (sample > prev.hi) ? sample : prev.hi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cur_reg <= cur_next;
        end
    end

    assign cur = cur_reg;

endmodule

FILE: rtl/core/swmm_select.sv
// Picks the cell that matches the window size and holds the result item.
// Depends on swmm_pkg.
module swmm_select
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int IW         = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  minmax_t         cells [WINDOW_MAX],
    input  logic [IW-1:0]   sel,
    input  logic            pend_valid,
    output logic            take,
    output logic            result_valid,
    input  logic            result_ready,
    output out_item_t       result
);

    logic      result_valid_reg;
    logic      result_valid_next;
    out_item_t result_reg;

    assign take = pend_valid && (!result_valid_reg || result_ready);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (take)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.window_min <= cells[sel].lo;
            result_reg.window_max <= cells[sel].hi;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/sliding_window_min_max.sv
// Sliding window min/max over a chain of WINDOW_MAX cells; one item per cycle sustained
// while the output register is not stalled. The cells and the pending flag update at
// the edge that accepts a sample, and the output register loads from the selected cell
// when it is free; a new sample every cycle unless the output register is stalled.
// Reset clears fill count, pending flags and sets window_size to 1; cell contents are
// left as they are, the fill count keeps them from being reported. Depends on swmm_pkg.
module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result
);

    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int KW = (FW > CFG_WIDTH) ? FW : CFG_WIDTH;
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [CFG_WIDTH-1:0] window_size_reg;
    logic [FW-1:0]        fill_count_reg;
    logic [FW-1:0]        fill_count_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [IW-1:0]        sel_reg;
    logic [IW-1:0]        sel_next;

    logic                 accept;
    logic                 take;
    logic [KW-1:0]        ws_ext;
    logic [KW-1:0]        k_eff;
    logic                 produce;

    minmax_t              chain_in  [WINDOW_MAX];
    minmax_t              chain_out [WINDOW_MAX];

    assign cfg_ready  = 1'b1;
    assign item_ready = !pend_valid_reg || take;
    assign accept     = item_valid && item_ready;

    // window size zero acts as one, oversize saturates
    always_comb
    begin
        ws_ext = KW'(window_size_reg);
        if (ws_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (ws_ext > KW'(WINDOW_MAX))
        begin
            k_eff = KW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = ws_ext;
        end
    end

    always_comb
    begin
        if (item.start_of_sequence)
        begin
            fill_count_next = FW'(1);
        end
        else if (fill_count_reg < FW'(WINDOW_MAX))
        begin
            fill_count_next = fill_count_reg + FW'(1);
        end
        else
        begin
            fill_count_next = fill_count_reg;
        end
        produce  = KW'(fill_count_next) >= k_eff;
        sel_next = IW'(k_eff - KW'(1));

        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = produce;
        end
        else if (take)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_WIDTH'(1);
            fill_count_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            sel_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_size_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
                sel_reg        <= sel_next;
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    // cell j covers the last j+1 samples; cell 0 starts from the sample alone
    genvar j;
    generate
        for (j = 0; j < WINDOW_MAX; j++)
        begin : g_cell
            if (j == 0)
            begin : g_head
                assign chain_in[j].lo = item.sample;
                assign chain_in[j].hi = item.sample;
            end
            else
            begin : g_link
                assign chain_in[j] = chain_out[j-1];
            end

            swmm_cell u_cell (
                .clk    (clk),
                .en     (accept),
                .sample (item.sample),
                .prev   (chain_in[j]),
                .cur    (chain_out[j])
            );
        end
    endgenerate

    swmm_select #(
        .WINDOW_MAX (WINDOW_MAX),
        .IW         (IW)
    ) u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .cells        (chain_out),
        .sel          (sel_reg),
        .pend_valid   (pend_valid_reg),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // a pending item always has a full window behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (KW'(fill_count_reg) >= KW'(sel_reg) + KW'(1)))
        else $error("pending item without a full window");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FW'(WINDOW_MAX))
        else $error("fill count beyond chain length");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.start_of_sequence |=> fill_count_reg == FW'(1))
        else $error("start of sequence did not restart fill count");

    // input only stalls behind a stalled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (pend_valid_reg && result_valid && !result_ready))
        else $error("input stalled without back pressure");

endmodule
